FILE: rtl/core/air_quality_forecast_alert_macros.svh
// Assertion macros shared by the air quality forecast blocks.
`ifndef AIR_QUALITY_FORECAST_ALERT_MACROS_SVH
`define AIR_QUALITY_FORECAST_ALERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AQF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aqf same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define AQF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aqf next-cycle check failed");

`endif

FILE: rtl/core/aqf_pkg.sv
// Types, constants and seed functions for the air quality forecast block.
`default_nettype none

package aqf_pkg;

   localparam int VAL_W    = 20;
   localparam int POLL     = 4;
   localparam int NUM_W    = 24;
   localparam int FAC_W    = 15;
   localparam int PROD_W   = 39;
   localparam int LIMSC_W  = 38;
   localparam int PY_W     = 32;
   localparam int PPM_W    = 61;

   localparam logic [VAL_W-1:0] VAL_MAX       = 20'd1048575;
   localparam logic [VAL_W-1:0] CO2_MIN_LIMIT = 20'd6400;
   localparam logic [VAL_W-1:0] PM25_LIM_RST  = 20'd240;
   localparam logic [VAL_W-1:0] NO2_LIM_RST   = 20'd400;
   localparam logic [VAL_W-1:0] SO2_LIM_RST   = 20'd640;
   localparam logic [VAL_W-1:0] CO2_LIM_RST   = 20'd16000;

   localparam logic signed [17:0] FACTOR_BASE = 18'sd14560;
   localparam logic signed [17:0] FACTOR_LO   = 18'sd11200;
   localparam logic signed [17:0] FACTOR_HI   = 18'sd24000;

   localparam logic [10:0] TEMP_RST = 11'd320;
   localparam logic [9:0]  WIND_RST = 10'd32;
   localparam logic [10:0] HUM_RST  = 11'd800;

   // 160000 = 256 * 625; rounding offset is half of it
   localparam logic [PROD_W:0] ROUND_HALF   = 40'd80000;
   localparam logic [PY_W-1:0] PY_SAT       = 32'd655360000;
   localparam logic [30:0]     RECIP_625    = 31'd1759218604;
   localparam logic [9:0]      DIV_625      = 10'd625;

   typedef logic [POLL-1:0][VAL_W-1:0] row_type;

   typedef enum logic [1:0] {
      CSR_PM25_LIMIT,
      CSR_NO2_LIMIT,
      CSR_SO2_LIMIT,
      CSR_CO2_LIMIT
   } csr_index_type;

   typedef enum logic [1:0] {
      DAY_NEXT,
      DAY_NEWEST,
      DAY_PREV1,
      DAY_PREV2
   } day_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_K_NUM,
      ST_K_MUL,
      ST_K_Q,
      ST_K_PM,
      ST_K_PQ,
      ST_K_PR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        load;
      logic        sweep;
      logic        mem_rd;
      day_sel_type day_sel;
      logic        upd_wr;
      logic        cap_h0;
      logic        cap_h1;
      logic        cap_h2;
      logic        k_num;
      logic        k_mul;
      logic        k_q;
      logic        k_pm;
      logic        k_pq;
      logic        k_pr;
      logic        publish;
   } cmd_type;

   typedef struct packed {
      logic req_zone_ok;
      logic req_reading;
      logic sweep_last;
      logic lane_last;
      logic out_free;
   } status_type;

   function automatic logic [VAL_W-1:0] seed_value(input logic [3:0] z, input logic [1:0] k);
      logic [VAL_W-1:0] zv;
      logic [VAL_W-1:0] r;
      zv = VAL_W'(z);
      unique case (k)
         2'd0:    r = (20'd10 + zv) << 4;
         2'd1:    r = (20'd15 + zv) << 4;
         2'd2:    r = (20'd20 + zv) << 4;
         default: r = (20'd800 + zv * 20'd10) << 4;
      endcase
      return r;
   endfunction

   function automatic row_type seed_row(input logic [3:0] z);
      row_type r;
      for (int k = 0; k < POLL; k++) begin
         r[k] = seed_value(z, 2'(k));
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/air_quality_forecast_alert.sv
// Air quality forecast top level: per-zone history, averages, forecasts and alerts.
// Sequence: a reading request passes through the history update before the row reads,
//   a request for a zone out of range goes straight to the result; the sequencer walks
//   four pollutant lanes through one shared multiplier pipeline.
// A new request is taken only in idle, once the previous one has been published to rsp.
// Reset: synchronous; afterwards a clearing pass over all ZONES*HISTORY_DAYS rows (240 by
//   default) seeds the history memory, req_stall stays high meanwhile, csr writes go on.
`default_nettype none

module air_quality_forecast_alert #(
   parameter int ZONES        = 8,
   parameter int HISTORY_DAYS = 30
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_kind,
   input  wire logic [2:0]         req_zone,
   input  wire logic [19:0]        req_pm25_reading,
   input  wire logic [19:0]        req_no2_reading,
   input  wire logic [19:0]        req_so2_reading,
   input  wire logic [19:0]        req_co2_reading,
   input  wire logic signed [10:0] req_temperature,
   input  wire logic [9:0]         req_wind_speed,
   input  wire logic [10:0]        req_humidity,
   // result channel
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [19:0]        rsp_pm25_average,
   output      logic [19:0]        rsp_no2_average,
   output      logic [19:0]        rsp_so2_average,
   output      logic [19:0]        rsp_co2_average,
   output      logic [19:0]        rsp_pm25_forecast,
   output      logic [19:0]        rsp_no2_forecast,
   output      logic [19:0]        rsp_so2_forecast,
   output      logic [19:0]        rsp_co2_forecast,
   output      logic [3:0]         rsp_alert_mask,
   // limit registers
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [19:0]        csr_wdata
);

   aqf_pkg::cmd_type    cmd;
   aqf_pkg::status_type status;
   aqf_pkg::row_type    avg_row;
   aqf_pkg::row_type    fc_row;

   // Sequencer: clear pass, optional history update, three row reads, four lanes.
   aqf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: holds all data state, the shared arithmetic and the result register,
   // so a finished result can wait on rsp_stall while the next request is taken.
   aqf_datapath #(
      .ZONES        (ZONES),
      .HISTORY_DAYS (HISTORY_DAYS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_zone         (req_zone),
      .req_pm25_reading (req_pm25_reading),
      .req_no2_reading  (req_no2_reading),
      .req_so2_reading  (req_so2_reading),
      .req_co2_reading  (req_co2_reading),
      .req_temperature  (req_temperature),
      .req_wind_speed   (req_wind_speed),
      .req_humidity     (req_humidity),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_average      (avg_row),
      .rsp_forecast     (fc_row),
      .rsp_alert_mask   (rsp_alert_mask)
   );

   // Lane order: PM2.5, NO2, SO2, CO2.
   assign rsp_pm25_average  = avg_row[0];
   assign rsp_no2_average   = avg_row[1];
   assign rsp_so2_average   = avg_row[2];
   assign rsp_co2_average   = avg_row[3];
   assign rsp_pm25_forecast = fc_row[0];
   assign rsp_no2_forecast  = fc_row[1];
   assign rsp_so2_forecast  = fc_row[2];
   assign rsp_co2_forecast  = fc_row[3];

endmodule

`default_nettype wire

FILE: rtl/core/aqf_ctrl.sv
// Sequencer for the air quality forecast datapath.
`default_nettype none

module aqf_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire aqf_pkg::status_type status,
   output      aqf_pkg::cmd_type    cmd
);

   aqf_pkg::state_type state_ff;
   aqf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aqf_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aqf_pkg::ST_CLEAR: begin
            if (status.sweep_last) state_in = aqf_pkg::ST_IDLE;
         end
         aqf_pkg::ST_IDLE: begin
            if (req_valid) begin
               priority if (!status.req_zone_ok) state_in = aqf_pkg::ST_DONE;
               else if (status.req_reading)      state_in = aqf_pkg::ST_UPD_RD;
               else                              state_in = aqf_pkg::ST_RD0;
            end
         end
         aqf_pkg::ST_UPD_RD: state_in = aqf_pkg::ST_UPD_WR;
         aqf_pkg::ST_UPD_WR: state_in = aqf_pkg::ST_RD0;
         aqf_pkg::ST_RD0:    state_in = aqf_pkg::ST_RD1;
         aqf_pkg::ST_RD1:    state_in = aqf_pkg::ST_RD2;
         aqf_pkg::ST_RD2:    state_in = aqf_pkg::ST_RD3;
         aqf_pkg::ST_RD3:    state_in = aqf_pkg::ST_K_NUM;
         aqf_pkg::ST_K_NUM:  state_in = aqf_pkg::ST_K_MUL;
         aqf_pkg::ST_K_MUL:  state_in = aqf_pkg::ST_K_Q;
         aqf_pkg::ST_K_Q:    state_in = aqf_pkg::ST_K_PM;
         aqf_pkg::ST_K_PM:   state_in = aqf_pkg::ST_K_PQ;
         aqf_pkg::ST_K_PQ:   state_in = aqf_pkg::ST_K_PR;
         aqf_pkg::ST_K_PR: begin
            state_in = status.lane_last ? aqf_pkg::ST_DONE : aqf_pkg::ST_K_NUM;
         end
         aqf_pkg::ST_DONE: begin
            if (status.out_free) state_in = aqf_pkg::ST_IDLE;
         end
         default: state_in = aqf_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         aqf_pkg::ST_CLEAR: cmd.sweep = 1'b1;
         aqf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         aqf_pkg::ST_UPD_RD: begin
            cmd.mem_rd  = 1'b1;
            cmd.day_sel = aqf_pkg::DAY_NEXT;
         end
         aqf_pkg::ST_UPD_WR: begin
            cmd.upd_wr  = 1'b1;
            cmd.day_sel = aqf_pkg::DAY_NEXT;
         end
         aqf_pkg::ST_RD0: begin
            cmd.mem_rd  = 1'b1;
            cmd.day_sel = aqf_pkg::DAY_NEWEST;
         end
         aqf_pkg::ST_RD1: begin
            cmd.mem_rd  = 1'b1;
            cmd.day_sel = aqf_pkg::DAY_PREV1;
            cmd.cap_h0  = 1'b1;
         end
         aqf_pkg::ST_RD2: begin
            cmd.mem_rd  = 1'b1;
            cmd.day_sel = aqf_pkg::DAY_PREV2;
            cmd.cap_h1  = 1'b1;
         end
         aqf_pkg::ST_RD3:   cmd.cap_h2 = 1'b1;
         aqf_pkg::ST_K_NUM: cmd.k_num  = 1'b1;
         aqf_pkg::ST_K_MUL: cmd.k_mul  = 1'b1;
         aqf_pkg::ST_K_Q:   cmd.k_q    = 1'b1;
         aqf_pkg::ST_K_PM:  cmd.k_pm   = 1'b1;
         aqf_pkg::ST_K_PQ:  cmd.k_pq   = 1'b1;
         aqf_pkg::ST_K_PR:  cmd.k_pr   = 1'b1;
         aqf_pkg::ST_DONE:  cmd.publish = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/aqf_datapath.sv
// History memory, window sums, weather and the shared forecast arithmetic.
`default_nettype none

`include "air_quality_forecast_alert_macros.svh"

module aqf_datapath #(
   parameter int ZONES        = 8,
   parameter int HISTORY_DAYS = 30
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire aqf_pkg::cmd_type        cmd,
   output      aqf_pkg::status_type     status,
   input  wire logic                    req_kind,
   input  wire logic [2:0]              req_zone,
   input  wire logic [19:0]             req_pm25_reading,
   input  wire logic [19:0]             req_no2_reading,
   input  wire logic [19:0]             req_so2_reading,
   input  wire logic [19:0]             req_co2_reading,
   input  wire logic signed [10:0]      req_temperature,
   input  wire logic [9:0]              req_wind_speed,
   input  wire logic [10:0]             req_humidity,
   input  wire logic                    csr_we,
   input  wire logic [1:0]              csr_index,
   input  wire logic [19:0]             csr_wdata,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      aqf_pkg::row_type        rsp_average,
   output      aqf_pkg::row_type        rsp_forecast,
   output      logic [3:0]              rsp_alert_mask
);

   localparam int ZIDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int DAY_W  = $clog2(HISTORY_DAYS);
   localparam int ROWS   = ZONES * HISTORY_DAYS;
   localparam int ADDR_W = $clog2(ROWS);
   localparam int SUM_W  = aqf_pkg::VAL_W + $clog2(HISTORY_DAYS);
   localparam int AVG_S  = SUM_W + 1;
   localparam logic [AVG_S-1:0] AVG_RECIP = AVG_S'((64'd1 << AVG_S) / HISTORY_DAYS);

   typedef logic [aqf_pkg::POLL-1:0][SUM_W-1:0] sum_row_type;

   // request latch
   logic                   kind_ff;
   logic [2:0]             zone_ff;
   aqf_pkg::row_type       reading_ff;
   logic signed [10:0]     temp_ff;
   logic [9:0]             wind_ff;
   logic [10:0]            hum_ff;

   // per-zone state
   logic [DAY_W-1:0]       ptr_ff    [ZONES];
   sum_row_type            sum_ff    [ZONES];
   logic signed [10:0]     wthr_t_ff [ZONES];
   logic [9:0]             wthr_v_ff [ZONES];
   logic [10:0]            wthr_h_ff [ZONES];

   aqf_pkg::row_type       hist_mem [ROWS];
   aqf_pkg::row_type       hist_rd_ff;

   logic [ZIDX_W-1:0]      sweep_zone_ff;
   logic [DAY_W-1:0]       sweep_day_ff;

   logic [aqf_pkg::VAL_W-1:0] lim_ff [aqf_pkg::POLL];

   aqf_pkg::row_type       h0_ff, h1_ff, h2_ff;
   logic [aqf_pkg::FAC_W-1:0] f_ff;
   logic [1:0]             lane_ff;

   logic [aqf_pkg::NUM_W-1:0]   num_ff;
   logic [AVG_S-1:0]            avg_y_ff;
   logic [aqf_pkg::LIMSC_W-1:0] limsc_ff;
   logic [aqf_pkg::PROD_W-1:0]  prod_ff;
   logic [2*AVG_S-1:0]          avg_p_ff;
   logic [aqf_pkg::PY_W-1:0]    py_ff;
   logic                        alert_k_ff;
   logic [aqf_pkg::VAL_W-1:0]   aq_ff;
   logic                        psat_ff;
   logic [aqf_pkg::PPM_W-1:0]   ppm_ff;
   logic [aqf_pkg::VAL_W-1:0]   pq_ff;

   aqf_pkg::row_type       res_avg_ff, res_fc_ff;
   logic [3:0]             res_alert_ff;

   logic                   rsp_valid_ff;
   aqf_pkg::row_type       rsp_avg_ff, rsp_fc_ff;
   logic [3:0]             rsp_alert_ff;

   // combinational
   logic [ZIDX_W-1:0]      zidx;
   logic [DAY_W-1:0]       cur_ptr, next_ptr, prev1_ptr, prev2_ptr, day_sel;
   logic [ADDR_W-1:0]      row_addr, sweep_addr, wr_addr;
   aqf_pkg::row_type       wr_row;
   logic                   mem_we;
   logic signed [17:0]     t_ext, v_ext, h_ext, f_raw;
   logic [aqf_pkg::FAC_W-1:0] f_clamp;
   logic [aqf_pkg::PROD_W:0]  psum;
   logic [AVG_S-1:0]       avg_rem;
   logic [29:0]            pred_rem;
   logic [aqf_pkg::VAL_W-1:0] fc_val;

   assign zidx     = ZIDX_W'(zone_ff);
   assign cur_ptr  = ptr_ff[zidx];
   assign next_ptr = (cur_ptr == DAY_W'(HISTORY_DAYS - 1)) ? '0 : cur_ptr + 1'b1;
   assign prev1_ptr = (cur_ptr == '0) ? DAY_W'(HISTORY_DAYS - 1) : cur_ptr - 1'b1;
   always_comb begin
      priority if (cur_ptr == '0)               prev2_ptr = DAY_W'(HISTORY_DAYS - 2);
      else if (cur_ptr == DAY_W'(1))            prev2_ptr = DAY_W'(HISTORY_DAYS - 1);
      else                                      prev2_ptr = cur_ptr - DAY_W'(2);
   end

   always_comb begin
      unique case (cmd.day_sel)
         aqf_pkg::DAY_NEXT:   day_sel = next_ptr;
         aqf_pkg::DAY_NEWEST: day_sel = cur_ptr;
         aqf_pkg::DAY_PREV1:  day_sel = prev1_ptr;
         aqf_pkg::DAY_PREV2:  day_sel = prev2_ptr;
         default:             day_sel = cur_ptr;
      endcase
   end

   assign row_addr   = ADDR_W'(zidx) * ADDR_W'(HISTORY_DAYS) + ADDR_W'(day_sel);
   assign sweep_addr = ADDR_W'(sweep_zone_ff) * ADDR_W'(HISTORY_DAYS) + ADDR_W'(sweep_day_ff);
   assign mem_we     = cmd.sweep | cmd.upd_wr;
   assign wr_addr    = cmd.sweep ? sweep_addr : row_addr;
   assign wr_row     = cmd.sweep ? aqf_pkg::seed_row(4'(sweep_zone_ff)) : reading_ff;

   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[wr_addr] <= wr_row;
      if (cmd.mem_rd) hist_rd_ff <= hist_mem[row_addr];
   end

   // clearing pass over the history memory
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_zone_ff <= '0;
         sweep_day_ff  <= '0;
      end else if (cmd.sweep) begin
         if (sweep_day_ff == DAY_W'(HISTORY_DAYS - 1)) begin
            sweep_day_ff  <= '0;
            sweep_zone_ff <= (sweep_zone_ff == ZIDX_W'(ZONES - 1)) ? '0 : sweep_zone_ff + 1'b1;
         end else begin
            sweep_day_ff <= sweep_day_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff       <= req_kind;
         zone_ff       <= req_zone;
         reading_ff[0] <= req_pm25_reading;
         reading_ff[1] <= req_no2_reading;
         reading_ff[2] <= req_so2_reading;
         reading_ff[3] <= req_co2_reading;
         temp_ff       <= req_temperature;
         wind_ff       <= req_wind_speed;
         hum_ff        <= req_humidity;
      end
   end

   // per-zone pointer, sums and weather
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < ZONES; z++) begin
            ptr_ff[z]    <= '0;
            wthr_t_ff[z] <= signed'(aqf_pkg::TEMP_RST);
            wthr_v_ff[z] <= aqf_pkg::WIND_RST;
            wthr_h_ff[z] <= aqf_pkg::HUM_RST;
            for (int k = 0; k < aqf_pkg::POLL; k++) begin
               sum_ff[z][k] <= SUM_W'(aqf_pkg::seed_value(4'(z), 2'(k)))
                               * SUM_W'(HISTORY_DAYS);
            end
         end
      end else if (cmd.upd_wr && !kind_ff) begin
         ptr_ff[zidx]    <= next_ptr;
         wthr_t_ff[zidx] <= temp_ff;
         wthr_v_ff[zidx] <= wind_ff;
         wthr_h_ff[zidx] <= hum_ff;
         for (int k = 0; k < aqf_pkg::POLL; k++) begin
            sum_ff[zidx][k] <= sum_ff[zidx][k] - SUM_W'(hist_rd_ff[k])
                               + SUM_W'(reading_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff[0] <= aqf_pkg::PM25_LIM_RST;
         lim_ff[1] <= aqf_pkg::NO2_LIM_RST;
         lim_ff[2] <= aqf_pkg::SO2_LIM_RST;
         lim_ff[3] <= aqf_pkg::CO2_LIM_RST;
      end else if (csr_we) begin
         unique case (aqf_pkg::csr_index_type'(csr_index))
            aqf_pkg::CSR_PM25_LIMIT: lim_ff[0] <= csr_wdata;
            aqf_pkg::CSR_NO2_LIMIT:  lim_ff[1] <= csr_wdata;
            aqf_pkg::CSR_SO2_LIMIT:  lim_ff[2] <= csr_wdata;
            aqf_pkg::CSR_CO2_LIMIT:  lim_ff[3] <= (csr_wdata < aqf_pkg::CO2_MIN_LIMIT) ?
                                                  aqf_pkg::CO2_MIN_LIMIT : csr_wdata;
            default: lim_ff[0] <= lim_ff[0];
         endcase
      end
   end

   // weather factor, scaled by 16000
   assign t_ext = 18'(wthr_t_ff[zidx]);
   assign v_ext = signed'(18'(wthr_v_ff[zidx]));
   assign h_ext = signed'(18'(wthr_h_ff[zidx]));
   assign f_raw = aqf_pkg::FACTOR_BASE + t_ext * 18'sd5 - v_ext * 18'sd30 + h_ext;
   always_comb begin
      priority if (f_raw < aqf_pkg::FACTOR_LO) f_clamp = aqf_pkg::FAC_W'(aqf_pkg::FACTOR_LO);
      else if (f_raw > aqf_pkg::FACTOR_HI)     f_clamp = aqf_pkg::FAC_W'(aqf_pkg::FACTOR_HI);
      else                                     f_clamp = f_raw[aqf_pkg::FAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_h0) h0_ff <= hist_rd_ff;
      if (cmd.cap_h1) h1_ff <= hist_rd_ff;
      if (cmd.cap_h2) begin
         h2_ff <= hist_rd_ff;
         f_ff  <= f_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else if (cmd.k_pr) begin
         lane_ff <= lane_ff + 1'b1;
      end
   end

   assign psum     = {1'b0, prod_ff} + aqf_pkg::ROUND_HALF;
   assign avg_rem  = avg_y_ff - AVG_S'(aq_ff) * AVG_S'(HISTORY_DAYS);
   assign pred_rem = py_ff[29:0] - 30'(pq_ff) * 30'(aqf_pkg::DIV_625);
   always_comb begin
      priority if (psat_ff)                   fc_val = aqf_pkg::VAL_MAX;
      else if (pred_rem >= 30'(aqf_pkg::DIV_625)) fc_val = pq_ff + 1'b1;
      else                                    fc_val = pq_ff;
   end

   // one pollutant lane at a time through the shared multipliers
   always_ff @(posedge clock) begin
      if (cmd.k_num) begin
         num_ff   <= aqf_pkg::NUM_W'(h0_ff[lane_ff]) * 24'd5
                   + aqf_pkg::NUM_W'(h1_ff[lane_ff]) * 24'd3
                   + aqf_pkg::NUM_W'(h2_ff[lane_ff]) * 24'd2;
         avg_y_ff <= AVG_S'(sum_ff[zidx][lane_ff]) + AVG_S'(HISTORY_DAYS / 2);
         limsc_ff <= (aqf_pkg::LIMSC_W'(lim_ff[lane_ff])
                      * aqf_pkg::LIMSC_W'(aqf_pkg::DIV_625)) << 8;
      end
      if (cmd.k_mul) begin
         prod_ff  <= aqf_pkg::PROD_W'(num_ff) * aqf_pkg::PROD_W'(f_ff);
         avg_p_ff <= (2*AVG_S)'(avg_y_ff) * (2*AVG_S)'(AVG_RECIP);
      end
      if (cmd.k_q) begin
         py_ff      <= psum[aqf_pkg::PROD_W:8];
         alert_k_ff <= prod_ff > {1'b0, limsc_ff};
         aq_ff      <= avg_p_ff[AVG_S+aqf_pkg::VAL_W-1:AVG_S];
      end
      if (cmd.k_pm) begin
         psat_ff <= py_ff >= aqf_pkg::PY_SAT;
         ppm_ff  <= aqf_pkg::PPM_W'(py_ff[29:0]) * aqf_pkg::PPM_W'(aqf_pkg::RECIP_625);
      end
      if (cmd.k_pq) begin
         pq_ff <= ppm_ff[59:40];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_avg_ff   <= '0;
         res_fc_ff    <= '0;
         res_alert_ff <= '0;
      end else begin
         if (cmd.k_pm) begin
            res_avg_ff[lane_ff] <= (avg_rem >= AVG_S'(HISTORY_DAYS)) ? aq_ff + 1'b1 : aq_ff;
         end
         if (cmd.k_pr) begin
            res_fc_ff[lane_ff]    <= fc_val;
            res_alert_ff[lane_ff] <= alert_k_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_avg_ff   <= res_avg_ff;
         rsp_fc_ff    <= res_fc_ff;
         rsp_alert_ff <= res_alert_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = rsp_avg_ff;
   assign rsp_forecast   = rsp_fc_ff;
   assign rsp_alert_mask = rsp_alert_ff;

   assign status.req_zone_ok = {2'b00, req_zone} < 5'(ZONES);
   assign status.req_reading = !req_kind;
   assign status.sweep_last  = (sweep_zone_ff == ZIDX_W'(ZONES - 1))
                               && (sweep_day_ff == DAY_W'(HISTORY_DAYS - 1));
   assign status.lane_last   = lane_ff == 2'd3;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   `AQF_ASSERT_NEXT(a_publish_shows, clock, reset, cmd.publish, rsp_valid_ff)
   `AQF_ASSERT_NEXT(a_lane_wraps, clock, reset, cmd.k_pr && lane_ff == 2'd3, lane_ff == 2'd0)
   `AQF_ASSERT_SAME(a_ptr_range, clock, reset, cmd.mem_rd, {1'b0, cur_ptr} < (DAY_W+1)'(HISTORY_DAYS))
   `AQF_ASSERT_SAME(a_co2_alert_level, clock, reset, rsp_valid_ff && rsp_alert_ff[3], rsp_fc_ff[3] >= lim_ff[3])

endmodule

`default_nettype wire
